// File: hw/rtl/stcs_pkg.sv
// Package: channel payload types, register indexes, gains and the sine table function.
package stcs_pkg;

  typedef struct packed {
    logic restart;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               last_sample;
    logic               playing;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } cfg_item_t;

  localparam logic [2:0] REG_START_INCREMENT = 3'd0;
  localparam logic [2:0] REG_INCREMENT_STEP  = 3'd1;
  localparam logic [2:0] REG_SAMPLE_COUNT    = 3'd2;
  localparam logic [2:0] REG_NOISE_SEED      = 3'd3;
  localparam logic [2:0] REG_DECAY_FACTOR    = 3'd4;

  localparam logic [30:0] START_INCREMENT_RST = 31'd27269700;
  localparam logic [31:0] INCREMENT_STEP_RST  = 32'd7228;
  localparam logic [15:0] SAMPLE_COUNT_RST    = 16'd4851;
  localparam logic [31:0] NOISE_SEED_RST      = 32'd11111;
  localparam logic [23:0] DECAY_FACTOR_RST    = 24'd16766149;

  localparam logic [31:0] NOISE_ADD   = 32'h6D2B79F5;
  localparam logic [31:0] TONE_GAIN   = 32'd42598;
  localparam logic [31:0] NOISE_GAIN4 = 32'd78644;

  // Serial multiplier: one 4-bit digit of the second operand per cycle.
  localparam int MUL_DIGIT = 4;
  localparam int MUL_STEPS = 32 / MUL_DIGIT;

  localparam logic [63:0] Q30_ONE    = 64'd1073741824;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // Quarter-wave sine entry in Q1.15 from a Q30 Taylor polynomial.
  function automatic logic [15:0] sine_quarter(input logic [63:0] m, input int bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] v;
    logic [63:0] s;
    logic [63:0] q;
    x  = (m * TWO_PI_Q30) >> bits;
    x2 = (x * x) >> 30;
    v  = Q30_ONE;
    v  = Q30_ONE - ((x2 * v) >> 30) / 110;
    v  = Q30_ONE - ((x2 * v) >> 30) / 72;
    v  = Q30_ONE - ((x2 * v) >> 30) / 42;
    v  = Q30_ONE - ((x2 * v) >> 30) / 20;
    v  = Q30_ONE - ((x2 * v) >> 30) / 6;
    s  = (x * v) >> 30;
    q  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) q = 64'd32767;
    return q[15:0];
  endfunction

endpackage

// File: hw/rtl/stcs_chan_if.sv
// Valid/ready channel interface carrying one payload item.
interface stcs_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/swept_tone_creak_synth_unit.sv
// Swept tone synthesizer: sine plus harmonic plus noise, decay envelope, serial multiplier.
//
//   channel  dir  payload                                   transfer when
//   in_ch    in   restart                                   valid && ready
//   out_ch   out  pcm_sample, last_sample, playing          valid && ready
//   cfg      in   index, value                              valid && ready
//
// A sample takes two table reads and seven passes of the 4-bit-digit serial
// multiplier, each with a hand-over; a step with no sound active skips them.
// cfg is always ready.
// Reset loads the register defaults and leaves the sound idle.
// in_ch is ready in idle; one finished result waits in the output register
// while the next item is taken, and the core holds if that register is full.
module swept_tone_creak_synth_unit
  import stcs_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic clk,
  input  logic rst,
  stcs_chan_if.sink   in_ch,
  stcs_chan_if.source out_ch,
  stcs_chan_if.sink   cfg
);

  localparam int TB      = SINE_TABLE_BITS;
  localparam int QUARTER = (1 << TB) / 4;
  localparam logic [TB-1:0] HALF_W    = TB'(1 << (TB - 1));
  localparam logic [TB-1:0] QUARTER_W = TB'(QUARTER);
  localparam longint FULL_SCALE = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_GAIN   = (FULL_SCALE * 45 * 256 + 50) / 100;

  typedef enum logic [3:0] {
    S_IDLE, S_TAB1, S_TAB2, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_DONE
  } state_t;

  state_t state;

  logic [30:0] start_increment;
  logic [31:0] increment_step;
  logic [15:0] sample_count;
  logic [31:0] noise_seed;
  logic [23:0] decay_factor;

  logic [31:0] phase_acc;
  logic [31:0] phase_increment;
  logic [24:0] envelope;
  logic [31:0] noise_state;
  logic [15:0] sample_index;
  logic        active;

  logic signed [15:0] s1;
  logic signed [15:0] s2;
  logic [31:0]        m1;
  logic signed [15:0] g;
  logic signed [15:0] pcm_r;
  logic               last_r;
  logic               play_r;
  logic               out_valid;
  out_item_t          out_data;

  // serial multiplier
  logic [63:0] acc;
  logic [63:0] ma;
  logic [31:0] mb;
  logic [$clog2(MUL_STEPS)-1:0] mul_cnt;
  logic        mul_busy;
  logic        mul_done;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_init;

  // sine table, quarter wave
  logic [15:0]   qtab [QUARTER+1];
  logic [TB-1:0] tab_idx;
  logic [TB-1:0] m_w;
  logic [15:0]   tab_q;
  logic [15:0]   tab_val;

  for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
    assign qtab[k] = sine_quarter(64'(k), TB);
  end

  always_comb begin
    tab_idx = (state == S_TAB1) ? phase_acc[31 -: TB] : phase_acc[30 -: TB];
    if ({1'b0, tab_idx[TB-2:0]} <= QUARTER_W) m_w = {1'b0, tab_idx[TB-2:0]};
    else m_w = HALF_W - {1'b0, tab_idx[TB-2:0]};
    tab_q   = qtab[m_w[TB-2:0]];
    tab_val = tab_idx[TB-1] ? (16'd0 - tab_q) : tab_q;
  end

  // derived values at multiplier hand-over points
  logic signed [63:0] acc_s;
  logic signed [63:0] mix_full;
  logic signed [63:0] mix_c;
  logic signed [63:0] pcm_full;
  logic signed [15:0] pcm_c;
  logic [31:0]        z2;
  logic [31:0]        noise_out;
  logic [63:0]        tone_sum;
  logic [16:0]        idx_plus;
  logic               last_c;

  always_comb begin
    acc_s    = $signed(acc);
    mix_full = acc_s >>> 18;
    if (mix_full > 64'sd32768) mix_c = 64'sd32768;
    else if (mix_full < -64'sd32768) mix_c = -64'sd32768;
    else mix_c = mix_full;
    pcm_full = acc_s >>> 32;
    if (pcm_full > 64'sd32767) pcm_c = 16'sd32767;
    else if (pcm_full < -64'sd32767) pcm_c = -16'sd32767;
    else pcm_c = pcm_full[15:0];
    z2        = m1 ^ acc[31:0];
    noise_out = z2 ^ (z2 >> 14);
    tone_sum  = ({{48{s1[15]}}, s1} << 2) + {{48{s2[15]}}, s2};
    idx_plus  = {1'b0, sample_index} + 17'd1;
    last_c    = (idx_plus >= {1'b0, sample_count});
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_init  = '0;
    unique case (state)
      S_TAB2: begin
        mul_start = 1'b1;
        mul_a     = {32'd0, noise_state ^ (noise_state >> 15)};
        mul_b     = noise_state | 32'd1;
      end
      S_M1: if (mul_done) begin
        mul_start = 1'b1;
        mul_a     = {32'd0, acc[31:0] ^ (acc[31:0] >> 7)};
        mul_b     = acc[31:0] | 32'd61;
        mul_init  = {32'd0, acc[31:0]};
      end
      S_M2: if (mul_done) begin
        mul_start = 1'b1;
        mul_a     = tone_sum;
        mul_b     = TONE_GAIN;
        mul_init  = 64'd1 << 17;
      end
      S_M3: if (mul_done) begin
        mul_start = 1'b1;
        mul_a     = {{48{g[15]}}, g};
        mul_b     = NOISE_GAIN4;
        mul_init  = acc;
      end
      S_M4: if (mul_done) begin
        mul_start = 1'b1;
        mul_a     = mix_c;
        mul_b     = {7'd0, envelope};
        mul_init  = 64'd1 << 14;
      end
      S_M5: if (mul_done) begin
        mul_start = 1'b1;
        mul_a     = acc_s >>> 15;
        mul_b     = 32'(OUT_GAIN);
        mul_init  = 64'd1 << 31;
      end
      S_M6: if (mul_done) begin
        mul_start = 1'b1;
        mul_a     = {39'd0, envelope};
        mul_b     = {8'd0, decay_factor};
        mul_init  = 64'd1 << 23;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
      mul_cnt  <= '0;
    end else begin
      mul_done <= 1'b0;
      if (mul_start) begin
        acc      <= mul_init;
        ma       <= mul_a;
        mb       <= mul_b;
        mul_cnt  <= '0;
        mul_busy <= 1'b1;
      end else if (mul_busy) begin
        acc     <= acc + ma * {60'd0, mb[MUL_DIGIT-1:0]};
        ma      <= ma << MUL_DIGIT;
        mb      <= mb >> MUL_DIGIT;
        mul_cnt <= mul_cnt + 1'b1;
        if (mul_cnt == ($clog2(MUL_STEPS))'(MUL_STEPS - 1)) begin
          mul_busy <= 1'b0;
          mul_done <= 1'b1;
        end
      end
    end
  end

  logic        acc_in;
  logic [31:0] base_phase;
  logic [31:0] base_inc;
  logic [31:0] base_noise;

  always_comb begin
    acc_in     = in_ch.valid && in_ch.ready;
    base_phase = in_ch.data.restart ? 32'd0 : phase_acc;
    base_inc   = in_ch.data.restart ? {1'b0, start_increment} : phase_increment;
    base_noise = in_ch.data.restart ? noise_seed : noise_state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      start_increment <= START_INCREMENT_RST;
      increment_step  <= INCREMENT_STEP_RST;
      sample_count    <= SAMPLE_COUNT_RST;
      noise_seed      <= NOISE_SEED_RST;
      decay_factor    <= DECAY_FACTOR_RST;
      phase_acc       <= '0;
      phase_increment <= {1'b0, START_INCREMENT_RST};
      envelope        <= 25'd1 << 24;
      noise_state     <= NOISE_SEED_RST;
      sample_index    <= '0;
      active          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.data.index)
          REG_START_INCREMENT: start_increment <= cfg.data.value[30:0];
          REG_INCREMENT_STEP:  increment_step  <= cfg.data.value;
          REG_SAMPLE_COUNT:    sample_count    <= cfg.data.value[15:0];
          REG_NOISE_SEED:      noise_seed      <= cfg.data.value;
          REG_DECAY_FACTOR:    decay_factor    <= cfg.data.value[23:0];
          default: ;
        endcase
      end
      // load a new result, else drop the one just transferred
      if (state == S_DONE && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (acc_in) begin
          if (in_ch.data.restart || active) begin
            phase_acc       <= base_phase + base_inc;
            phase_increment <= base_inc;
            noise_state     <= base_noise + NOISE_ADD;
            if (in_ch.data.restart) begin
              envelope     <= 25'd1 << 24;
              sample_index <= '0;
              active       <= 1'b1;
            end
            state <= S_TAB1;
          end else begin
            pcm_r  <= '0;
            last_r <= 1'b0;
            play_r <= 1'b0;
            state  <= S_DONE;
          end
        end
        S_TAB1: begin
          s1    <= tab_val;
          state <= S_TAB2;
        end
        S_TAB2: begin
          s2    <= tab_val;
          state <= S_M1;
        end
        S_M1: if (mul_done) begin
          m1    <= acc[31:0];
          state <= S_M2;
        end
        S_M2: if (mul_done) begin
          g     <= {~noise_out[31], noise_out[30:16]};
          state <= S_M3;
        end
        S_M3: if (mul_done) state <= S_M4;
        S_M4: if (mul_done) state <= S_M5;
        S_M5: if (mul_done) state <= S_M6;
        S_M6: if (mul_done) begin
          pcm_r <= pcm_c;
          state <= S_M7;
        end
        S_M7: if (mul_done) begin
          envelope        <= acc[48:24];
          phase_increment <= phase_increment + increment_step;
          sample_index    <= idx_plus[15:0];
          last_r          <= last_c;
          play_r          <= 1'b1;
          if (last_c) active <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: if (!out_valid || out_ch.ready) begin
          out_data  <= '{pcm_sample: pcm_r, last_sample: last_r, playing: play_r};
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  a_mul_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_busy |-> (state == S_M1 || state == S_M2 || state == S_M3 || state == S_M4 ||
                  state == S_M5 || state == S_M6 || state == S_M7))
    else $error("multiplier running outside a multiply state");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.playing) |-> (out_data.pcm_sample == 16'sd0 && !out_data.last_sample))
    else $error("idle result carries a sample");

  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    (state == S_M7 && mul_done && last_c) |=> !active)
    else $error("sound still active after its last sample");

endmodule

// File: test/tb.sv
// Testbench: directed and random restart/advance items checked against a sample predictor.
module tb;
  import stcs_pkg::*;

  localparam int TAB_BITS = 10;
  localparam int TAB_N = 1 << TAB_BITS;
  localparam longint OUT_K = ((64'd32767 * 45 * 256) + 50) / 100;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst;

  stcs_chan_if #(in_item_t)  in_ch();
  stcs_chan_if #(out_item_t) out_ch();
  stcs_chan_if #(cfg_item_t) cfg_ch();

  swept_tone_creak_synth_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg    (cfg_ch.sink)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // predictor state
  int          sine_rom [TAB_N];
  logic [30:0] m_start;
  logic [31:0] m_step;
  logic [15:0] m_count;
  logic [31:0] m_seed;
  logic [23:0] m_decay;
  logic [31:0] m_phase, m_inc, m_noise;
  logic [31:0] m_env;
  logic [15:0] m_index;
  logic        m_active;

  out_item_t   pending_samples [$];
  int          mismatches;
  bit          quiet;   // disable input gaps and output stalls
  longint      cycles;

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic int quarter_wave(int m);
    longint unsigned x, x2, v, s, q;
    longint unsigned dv [5];
    dv = '{110, 72, 42, 20, 6};
    x = (longint'(m) * 64'd6746518852) / TAB_N;
    x2 = (x * x) >> 30;
    v = 64'd1073741824;
    for (int i = 0; i < 5; i++) v = 64'd1073741824 - ((x2 * v) >> 30) / dv[i];
    s = (x * v) >> 30;
    q = (s * 32767 + (64'd1 << 29)) >> 30;
    if (q > 32767) q = 32767;
    return int'(q);
  endfunction

  function automatic logic [31:0] mulberry_out(logic [31:0] z);
    z = (z ^ (z >> 15)) * (z | 32'd1);
    z ^= z + (z ^ (z >> 7)) * (z | 32'd61);
    return z ^ (z >> 14);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_START_INCREMENT: m_start = val[30:0];
      REG_INCREMENT_STEP:  m_step = val;
      REG_SAMPLE_COUNT:    m_count = val[15:0];
      REG_NOISE_SEED:      m_seed = val;
      REG_DECAY_FACTOR:    m_decay = val[23:0];
      default: ;
    endcase
  endtask

  function automatic out_item_t synth_sample(logic rs);
    out_item_t r;
    longint s1, s2, g, mix, t, pcm;
    logic [31:0] p2;
    logic last;
    if (rs) begin
      m_phase = 0; m_inc = {1'b0, m_start}; m_env = 32'h0100_0000;
      m_noise = m_seed; m_index = 0; m_active = 1'b1;
    end
    r = '0;
    if (!m_active) return r;
    m_phase += m_inc;
    p2 = m_phase << 1;
    s1 = sine_rom[m_phase >> (32 - TAB_BITS)];
    s2 = sine_rom[p2 >> (32 - TAB_BITS)];
    m_noise += NOISE_ADD;
    g = longint'(mulberry_out(m_noise) >> 16) - 32768;
    mix = round_sh((4 * s1 + s2) * 42598 + g * 19661 * 4, 18);
    if (mix > 32768) mix = 32768;
    if (mix < -32768) mix = -32768;
    t = round_sh(mix * longint'(m_env), 15);
    pcm = round_sh(t * OUT_K, 32);
    if (pcm > 32767) pcm = 32767;
    if (pcm < -32767) pcm = -32767;
    last = (32'(m_index) + 1 >= 32'(m_count));
    r.pcm_sample = pcm[15:0];
    r.last_sample = last;
    r.playing = 1'b1;
    m_env = 32'((longint'(m_env) * m_decay + (1 << 23)) >> 24);
    m_inc += m_step;
    m_index += 1;
    if (last) m_active = 1'b0;
    return r;
  endfunction

  // send one item; exp_known marks a typed-in expectation
  task automatic send_item(input logic rs, input bit exp_known, input out_item_t exp_val);
    out_item_t p;
    while (!quiet && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    p = synth_sample(rs);
    if (exp_known && p !== exp_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("predictor disagrees with table: exp %h got %h", exp_val, p);
    end
    pending_samples.push_back(p);
    in_ch.valid <= 1'b1;
    in_ch.data <= '{restart: rs};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // output side
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected sample %h", out_ch.data);
        end else begin
          e = pending_samples.pop_front();
          if (out_ch.data.pcm_sample !== e.pcm_sample ||
              out_ch.data.last_sample !== e.last_sample ||
              out_ch.data.playing !== e.playing) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample mismatch: exp pcm %0d last %b play %b, got pcm %0d last %b play %b",
                       e.pcm_sample, e.last_sample, e.playing, out_ch.data.pcm_sample,
                       out_ch.data.last_sample, out_ch.data.playing);
          end
        end
      end
      out_ch.ready <= quiet || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  typedef struct {
    logic rs;
    bit known;
    out_item_t val;
  } row_t;

  row_t plan [$];

  initial begin
    out_item_t zero_item;
    int burst;
    zero_item = '0;
    cycles = 0;
    mismatches = 0;
    quiet = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    for (int a = 0; a < TAB_N; a++) begin
      int h, m, v;
      h = a % (TAB_N / 2);
      m = (h <= TAB_N / 4) ? h : TAB_N / 2 - h;
      v = quarter_wave(m);
      sine_rom[a] = (a >= TAB_N / 2) ? -v : v;
    end
    m_start = START_INCREMENT_RST; m_step = INCREMENT_STEP_RST;
    m_count = SAMPLE_COUNT_RST; m_seed = NOISE_SEED_RST; m_decay = DECAY_FACTOR_RST;
    m_phase = 0; m_inc = {1'b0, m_start}; m_env = 32'h0100_0000;
    m_noise = m_seed; m_index = 0; m_active = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle steps after reset are all zero, then two restarted sounds
    plan = '{'{1'b0, 1'b1, zero_item}, '{1'b0, 1'b1, zero_item},
             '{1'b1, 1'b0, zero_item}, '{1'b0, 1'b0, zero_item},
             '{1'b1, 1'b0, zero_item}, '{1'b0, 1'b0, zero_item}};
    foreach (plan[i]) send_item(plan[i].rs, plan[i].known, plan[i].val);
    drain();
    // extremes: zero-count (one-sample), three-sample and 65535-count sounds, full-scale and zero settings
    write_reg(REG_SAMPLE_COUNT, 32'd0);
    write_reg(REG_START_INCREMENT, 32'h7FFF_FFFF);
    write_reg(REG_INCREMENT_STEP, 32'h8000_0000);
    write_reg(REG_NOISE_SEED, 32'hFFFF_FFFF);
    write_reg(REG_DECAY_FACTOR, 32'hFF_FFFF);
    plan = '{'{1'b1, 1'b0, zero_item}, '{1'b0, 1'b1, zero_item},
             '{1'b1, 1'b0, zero_item}, '{1'b0, 1'b1, zero_item}};
    foreach (plan[i]) send_item(plan[i].rs, plan[i].known, plan[i].val);
    drain();
    write_reg(REG_SAMPLE_COUNT, 32'd3);
    write_reg(REG_START_INCREMENT, 32'd0);
    write_reg(REG_INCREMENT_STEP, 32'h7FFF_FFFF);
    write_reg(REG_NOISE_SEED, 32'd0);
    write_reg(REG_DECAY_FACTOR, 32'd0);
    for (int i = 0; i < 5; i++) send_item(i == 0, 1'b0, zero_item);
    drain();
    write_reg(REG_SAMPLE_COUNT, 32'hFFFF);
    write_reg(REG_DECAY_FACTOR, 32'hFF_FFFF);
    for (int i = 0; i < 6; i++) send_item(i == 0 || i == 4, 1'b0, zero_item);
    drain();

    // random phases of well-formed sounds with random settings
    for (int ph = 0; ph < 24; ph++) begin
      quiet = (ph >= 10 && ph < 13);
      write_reg(REG_START_INCREMENT, $urandom());
      write_reg(REG_INCREMENT_STEP, ($urandom_range(1)) ? $urandom() : $urandom_range(20000) - 10000);
      write_reg(REG_SAMPLE_COUNT, ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1, 60));
      write_reg(REG_NOISE_SEED, $urandom());
      write_reg(REG_DECAY_FACTOR, ($urandom_range(3) == 0) ? $urandom() : 24'hFF_FFFF - $urandom_range(5000));
      burst = 58;
      for (int i = 0; i < burst; i++)
        send_item(i == 0 || $urandom_range(99) < 4, 1'b0, zero_item);
      drain();
    end
    quiet = 1'b0;
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
